>>> rtl/rlpc_pkg.sv
// ----------------------------------------------------------------------------
// rlpc_pkg - shared types and constants for the RGBW lamp palette controller
// Word layouts, configuration view, queue entry, opcode and state codes.
// ----------------------------------------------------------------------------
package rlpc_pkg;

	localparam int unsigned PaletteDepth      = 16;
	localparam int unsigned HeartbeatPeriodMs = 10000;
	localparam int unsigned QueueDepth        = 2;
	localparam int unsigned LenW              = 5;
	localparam int unsigned SigW              = 16;
	localparam int unsigned CfgAddrW          = 5;
	localparam int unsigned CfgDataW          = 32;

	// input kind codes
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_TOGGLE = 3'd1;
	localparam logic [2:0] KIND_STEP   = 3'd2;
	localparam logic [2:0] KIND_SET    = 3'd3;
	localparam logic [2:0] KIND_SELECT = 3'd4;
	localparam logic [2:0] KIND_WRITE  = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_LOW_MEANS_ON     = 3'd0;
	localparam logic [2:0] REG_PALETTE_LENGTH   = 3'd1;
	localparam logic [2:0] REG_WHITE_PRESENT    = 3'd2;
	localparam logic [2:0] REG_HEARTBEAT_ENABLE = 3'd3;
	localparam logic [2:0] REG_AUTO_OFF         = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_TOGGLE,
		OP_STEP,
		OP_SET,
		OP_SELECT,
		OP_WRITE
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_DIV,
		BK_READ,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        now_ms;
		logic signed [15:0] step_amount;
		logic [15:0]        signal_index;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
		logic [7:0]         white_in;
	} in_word_t;

	typedef struct packed {
		logic        drive_valid;
		logic [15:0] drive_red;
		logic [15:0] drive_green;
		logic [15:0] drive_blue;
		logic [15:0] drive_white;
		logic        heartbeat;
		logic        changed;
		logic        lamp_active;
		logic [3:0]  current_index;
		logic [31:0] off_deadline;
	} out_word_t;

	typedef struct packed {
		logic            low_means_on;
		logic [LenW-1:0] palette_length;
		logic            white_present;
		logic            heartbeat_enable;
		logic [31:0]     auto_off_interval;
	} cfg_t;

	// color packed as {red, green, blue, white}
	typedef struct packed {
		op_t                op;
		logic [31:0]        now;
		logic signed [15:0] step;
		logic [SigW-1:0]    sig;
		logic [31:0]        color;
	} q_entry_t;

	typedef struct packed {
		logic            start;
		logic            neg;
		logic [SigW-1:0] dividend;
		logic [LenW-1:0] divisor;
	} div_req_t;

	// invert unless low_means_on, then widen with 255 -> 65535
	function automatic logic [15:0] widen_chan(input logic [7:0] c, input logic lmo);
		logic [7:0] v;
		v = lmo ? c : ~c;
		return (v == 8'hFF) ? 16'hFFFF : {v, 8'h00};
	endfunction

endpackage

>>> rtl/rlpc_front.sv
// ----------------------------------------------------------------------------
// rlpc_front - input stage
// Takes input words, decodes the kind into an opcode and pushes an entry
// into the command queue.
// ----------------------------------------------------------------------------
module rlpc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rlpc_pkg::in_word_t  in_data,
	input  logic                full,
	output logic                push,
	output rlpc_pkg::q_entry_t  push_entry
);

	logic               valid_s1;
	rlpc_pkg::q_entry_t entry_s1;
	rlpc_pkg::q_entry_t entry_d;

	assign in_stall   = valid_s1 && full;
	assign push       = valid_s1 && !full;
	assign push_entry = entry_s1;

	always_comb begin
		entry_d.now   = in_data.now_ms;
		entry_d.sig   = in_data.signal_index;
		entry_d.color = {in_data.red_in, in_data.green_in, in_data.blue_in, in_data.white_in};
		// a zero step counts as one
		entry_d.step  = (in_data.step_amount == 16'sd0) ? 16'sd1 : in_data.step_amount;
		case (in_data.kind)
			rlpc_pkg::KIND_TICK:   entry_d.op = rlpc_pkg::OP_TICK;
			rlpc_pkg::KIND_TOGGLE: entry_d.op = rlpc_pkg::OP_TOGGLE;
			rlpc_pkg::KIND_STEP:   entry_d.op = rlpc_pkg::OP_STEP;
			rlpc_pkg::KIND_SET:    entry_d.op = rlpc_pkg::OP_SET;
			rlpc_pkg::KIND_SELECT: entry_d.op = rlpc_pkg::OP_SELECT;
			rlpc_pkg::KIND_WRITE:  entry_d.op = rlpc_pkg::OP_WRITE;
			default:               entry_d.op = rlpc_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

>>> rtl/rlpc_queue.sv
// ----------------------------------------------------------------------------
// rlpc_queue - command queue between front and back
// Small FIFO of decoded entries.
// ----------------------------------------------------------------------------
module rlpc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rlpc_pkg::q_entry_t push_entry,
	input  logic               pop,
	output logic               full,
	output logic               head_valid,
	output rlpc_pkg::q_entry_t head
);

	localparam int unsigned PtrW = (rlpc_pkg::QueueDepth > 1) ? $clog2(rlpc_pkg::QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(rlpc_pkg::QueueDepth + 1);

	rlpc_pkg::q_entry_t entries_q [rlpc_pkg::QueueDepth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;

	assign full       = (count_q == CntW'(rlpc_pkg::QueueDepth));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(rlpc_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(rlpc_pkg::QueueDepth))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

endmodule

>>> rtl/rlpc_mod.sv
// ----------------------------------------------------------------------------
// rlpc_mod - bit-serial modulo unit
// Restoring remainder, one dividend bit per cycle, then a correction step
// that folds a negative dividend into [0, divisor).
// ----------------------------------------------------------------------------
module rlpc_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rlpc_pkg::div_req_t             req,
	output logic                           done,
	output logic [rlpc_pkg::LenW-1:0]      result
);

	localparam int unsigned SigW = rlpc_pkg::SigW;
	localparam int unsigned LenW = rlpc_pkg::LenW;
	localparam int unsigned CntW = $clog2(SigW);

	logic            busy_q;
	logic            fix_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [LenW-1:0] rem_q;
	logic [SigW-1:0] dvd_q;
	logic            neg_q;
	logic [LenW-1:0] len_q;
	logic [LenW-1:0] res_q;
	logic [LenW:0]   trial;
	logic [LenW:0]   diff;

	assign trial  = {rem_q, dvd_q[SigW-1]};
	assign diff   = trial - {1'b0, len_q};
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(SigW - 1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			neg_q <= req.neg;
			len_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= (trial >= {1'b0, len_q}) ? diff[LenW-1:0] : trial[LenW-1:0];
			dvd_q <= {dvd_q[SigW-2:0], 1'b0};
		end else if (fix_q) begin
			// true modulo: -m mod n = n - (m mod n) unless zero
			res_q <= (neg_q && rem_q != '0) ? len_q - rem_q : rem_q;
		end
	end

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q < len_q))
		else $error("modulo result not below divisor");

endmodule

>>> rtl/rlpc_back.sv
// ----------------------------------------------------------------------------
// rlpc_back - command execution
// Pops queue entries, runs palette index math on the modulo unit, writes and
// reads the palette memory, updates lamp state and loads the output register.
// ----------------------------------------------------------------------------
module rlpc_back #(
	parameter int unsigned PALETTE_DEPTH       = rlpc_pkg::PaletteDepth,
	parameter int unsigned HEARTBEAT_PERIOD_MS = rlpc_pkg::HeartbeatPeriodMs
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlpc_pkg::cfg_t      cfg,
	input  logic                head_valid,
	input  rlpc_pkg::q_entry_t  head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output rlpc_pkg::out_word_t out_data
);

	localparam int unsigned IW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int unsigned LenW = rlpc_pkg::LenW;
	localparam int unsigned SigW = rlpc_pkg::SigW;

	rlpc_pkg::bk_state_t state_q, state_d;
	rlpc_pkg::q_entry_t  work_q;
	logic                use_pal_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       last_index_q;
	logic                active_q;
	logic                change_pending_q;
	logic [31:0]         last_hb_q;
	logic [31:0]         deadline_q;
	logic [31:0]         pal_mem [PALETTE_DEPTH];
	logic [31:0]         rd_q;
	rlpc_pkg::out_word_t out_q;
	logic                out_valid_q;

	logic                slot_free;
	logic                needs_div;
	logic                rd_en;
	logic                fin_fire;
	logic                pal_we;
	logic                div_start;
	logic [LenW-1:0]     eff_len;
	rlpc_pkg::div_req_t  div_req;
	logic                div_done;
	logic [LenW-1:0]     div_res;
	logic [IW+LenW-1:0]  res_ext;
	logic signed [SigW:0] li_s;
	logic signed [SigW:0] step_s;
	logic signed [SigW:0] sum_s;
	logic signed [SigW:0] mag_s;

	logic                is_show;
	logic                is_tick;
	logic [31:0]         color;
	logic                hb;
	logic                active_d;
	logic [IW-1:0]       li_d;
	logic [IW+3:0]       li_ext;
	logic [31:0]         deadline_d;
	rlpc_pkg::out_word_t out_d;

	// ------------------------------------------------------------------ control
	assign slot_free = !out_valid_q || !out_stall;
	assign needs_div = (work_q.op == rlpc_pkg::OP_STEP) || (work_q.op == rlpc_pkg::OP_SELECT) ||
		((work_q.op == rlpc_pkg::OP_TOGGLE) && !active_q);

	always_comb begin
		eff_len = cfg.palette_length;
		if (cfg.palette_length == '0) begin
			eff_len = LenW'(1);
		end else if (32'(cfg.palette_length) > PALETTE_DEPTH) begin
			eff_len = LenW'(PALETTE_DEPTH);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rlpc_pkg::BK_IDLE: if (head_valid) state_d = rlpc_pkg::BK_EXEC;
			rlpc_pkg::BK_EXEC: state_d = needs_div ? rlpc_pkg::BK_DIV : rlpc_pkg::BK_FIN;
			rlpc_pkg::BK_DIV:  if (div_done) state_d = rlpc_pkg::BK_READ;
			rlpc_pkg::BK_READ: state_d = rlpc_pkg::BK_FIN;
			rlpc_pkg::BK_FIN:  if (slot_free) state_d = rlpc_pkg::BK_IDLE;
			default:           state_d = rlpc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		rd_en     = 1'b0;
		fin_fire  = 1'b0;
		case (state_q)
			rlpc_pkg::BK_IDLE: pop = head_valid;
			rlpc_pkg::BK_EXEC: div_start = needs_div;
			rlpc_pkg::BK_READ: rd_en = 1'b1;
			rlpc_pkg::BK_FIN:  fin_fire = slot_free;
			default: begin
			end
		endcase
	end

	// operand for the modulo unit
	assign li_s   = $signed((SigW+1)'(last_index_q));
	assign step_s = (SigW+1)'(work_q.step);
	assign sum_s  = li_s + step_s;
	assign mag_s  = sum_s[SigW] ? -sum_s : sum_s;

	always_comb begin
		div_req.start   = div_start;
		div_req.divisor = eff_len;
		case (work_q.op)
			rlpc_pkg::OP_STEP: begin
				div_req.neg      = sum_s[SigW];
				div_req.dividend = mag_s[SigW-1:0];
			end
			rlpc_pkg::OP_SELECT: begin
				div_req.neg      = 1'b0;
				div_req.dividend = work_q.sig;
			end
			default: begin
				div_req.neg      = 1'b0;
				div_req.dividend = SigW'(last_index_q);
			end
		endcase
	end

	rlpc_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.result (div_res)
	);

	assign res_ext = (IW+LenW)'(div_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlpc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
		end
		if (state_q == rlpc_pkg::BK_EXEC) begin
			use_pal_q <= needs_div;
		end
		if (state_q == rlpc_pkg::BK_DIV && div_done) begin
			idx_q <= res_ext[IW-1:0];
		end
	end

	// ------------------------------------------------------------------ palette
	assign pal_we = fin_fire && (work_q.op == rlpc_pkg::OP_WRITE) &&
		(work_q.sig < SigW'(PALETTE_DEPTH));

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[work_q.sig[IW-1:0]] <= work_q.color;
		end
		if (rd_en) begin
			rd_q <= pal_mem[idx_q];
		end
	end

	// ------------------------------------------------------------------ execute
	assign is_show = (work_q.op == rlpc_pkg::OP_TOGGLE) || (work_q.op == rlpc_pkg::OP_STEP) ||
		(work_q.op == rlpc_pkg::OP_SET) || (work_q.op == rlpc_pkg::OP_SELECT);
	assign is_tick = (work_q.op == rlpc_pkg::OP_TICK);

	// toggle from on shows all zero
	assign color = use_pal_q ? rd_q :
		((work_q.op == rlpc_pkg::OP_SET) ? work_q.color : 32'h0);

	// elapsed time wraps mod 2^32
	assign hb = is_tick && cfg.heartbeat_enable && active_q &&
		((work_q.now - last_hb_q) > 32'(HEARTBEAT_PERIOD_MS));

	always_comb begin
		active_d   = active_q;
		li_d       = last_index_q;
		deadline_d = deadline_q;
		if (is_show) begin
			active_d = (color != 32'h0);
			if (use_pal_q) begin
				li_d = idx_q;
			end
			if (cfg.auto_off_interval != 32'h0) begin
				deadline_d = work_q.now + cfg.auto_off_interval;
			end
		end
	end

	assign li_ext = (IW+4)'(li_d);

	always_comb begin
		out_d               = '0;
		out_d.drive_valid   = is_show;
		if (is_show) begin
			out_d.drive_red   = rlpc_pkg::widen_chan(color[31:24], cfg.low_means_on);
			out_d.drive_green = rlpc_pkg::widen_chan(color[23:16], cfg.low_means_on);
			out_d.drive_blue  = rlpc_pkg::widen_chan(color[15:8], cfg.low_means_on);
			if (cfg.white_present) begin
				out_d.drive_white = rlpc_pkg::widen_chan(color[7:0], cfg.low_means_on);
			end
		end
		out_d.heartbeat     = hb;
		out_d.changed       = is_tick && change_pending_q;
		out_d.lamp_active   = active_d;
		out_d.current_index = li_ext[3:0];
		out_d.off_deadline  = deadline_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q     <= '0;
			active_q         <= 1'b0;
			change_pending_q <= 1'b0;
			last_hb_q        <= '0;
			deadline_q       <= '1;
			out_valid_q      <= 1'b0;
		end else begin
			if (fin_fire) begin
				last_index_q <= li_d;
				active_q     <= active_d;
				deadline_q   <= deadline_d;
				if (is_show) begin
					change_pending_q <= 1'b1;
				end else if (is_tick) begin
					change_pending_q <= 1'b0;
				end
				if (hb) begin
					last_hb_q <= work_q.now;
				end
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && !is_show |=> (out_q.drive_red == '0 && out_q.drive_green == '0 &&
			out_q.drive_blue == '0 && out_q.drive_white == '0 && !out_q.drive_valid))
		else $error("drive values on a word without drive");

	a_white_absent: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && !cfg.white_present |=> (out_q.drive_white == '0))
		else $error("white driven while absent");

endmodule

>>> rtl/rgbw_lamp_palette_controller_core.sv
// ----------------------------------------------------------------------------
// rgbw_lamp_palette_controller_core - RGBW lamp controller with color palette
// Front stage and command queue feed an execution back end; APB registers.
// ----------------------------------------------------------------------------
// Flow: tick, set color, palette write and toggle-off words pass the back end
//   states EXEC and FIN; step, select and toggle-on also pass DIV and READ,
//   for the bit-serial modulo and the palette read.
// The back end runs one word at a time and pops the next only when it is done.
// Reset: asynchronous, clears lamp state, queue and output valid and loads
//   register defaults; palette contents are unknown until written.
module rgbw_lamp_palette_controller_core #(
	parameter int unsigned PALETTE_DEPTH       = rlpc_pkg::PaletteDepth,
	parameter int unsigned HEARTBEAT_PERIOD_MS = rlpc_pkg::HeartbeatPeriodMs
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rlpc_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rlpc_pkg::out_word_t                 out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rlpc_pkg::CfgAddrW-1:0]       paddr,
	input  logic [rlpc_pkg::CfgDataW-1:0]       pwdata,
	output logic [rlpc_pkg::CfgDataW-1:0]       prdata,
	output logic                                pready
);

	logic                          low_means_on_q;
	logic [rlpc_pkg::LenW-1:0]     palette_length_q;
	logic                          white_present_q;
	logic                          heartbeat_enable_q;
	logic [31:0]                   auto_off_interval_q;
	logic                          cfg_wr;
	logic [2:0]                    reg_idx;
	rlpc_pkg::cfg_t                cfg;

	logic                          q_full;
	logic                          q_push;
	rlpc_pkg::q_entry_t            q_push_entry;
	logic                          q_pop;
	logic                          q_head_valid;
	rlpc_pkg::q_entry_t            q_head;

	// --------------------------------------------------------------- registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_means_on_q      <= 1'b0;
			palette_length_q    <= rlpc_pkg::LenW'(1);
			white_present_q     <= 1'b1;
			heartbeat_enable_q  <= 1'b0;
			auto_off_interval_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				rlpc_pkg::REG_LOW_MEANS_ON:     low_means_on_q      <= pwdata[0];
				rlpc_pkg::REG_PALETTE_LENGTH:   palette_length_q    <= pwdata[rlpc_pkg::LenW-1:0];
				rlpc_pkg::REG_WHITE_PRESENT:    white_present_q     <= pwdata[0];
				rlpc_pkg::REG_HEARTBEAT_ENABLE: heartbeat_enable_q  <= pwdata[0];
				rlpc_pkg::REG_AUTO_OFF:         auto_off_interval_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rlpc_pkg::REG_LOW_MEANS_ON:     prdata = 32'(low_means_on_q);
			rlpc_pkg::REG_PALETTE_LENGTH:   prdata = 32'(palette_length_q);
			rlpc_pkg::REG_WHITE_PRESENT:    prdata = 32'(white_present_q);
			rlpc_pkg::REG_HEARTBEAT_ENABLE: prdata = 32'(heartbeat_enable_q);
			rlpc_pkg::REG_AUTO_OFF:         prdata = auto_off_interval_q;
			default:                        prdata = '0;
		endcase
	end

	always_comb begin
		cfg.low_means_on      = low_means_on_q;
		cfg.palette_length    = palette_length_q;
		cfg.white_present     = white_present_q;
		cfg.heartbeat_enable  = heartbeat_enable_q;
		cfg.auto_off_interval = auto_off_interval_q;
	end

	// --------------------------------------------------------------- datapath
	rlpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.full       (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	rlpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	rlpc_back #(
		.PALETTE_DEPTH       (PALETTE_DEPTH),
		.HEARTBEAT_PERIOD_MS (HEARTBEAT_PERIOD_MS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
